### rtl/core/gimbal_point_interpolator_top_defines.svh
// assertion macros shared by the gimbal point interpolator rtl
// no dependencies
`ifndef GIMBAL_POINT_INTERPOLATOR_TOP_DEFINES_SVH
`define GIMBAL_POINT_INTERPOLATOR_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpi assertion failed");

// antecedent implies consequent in the next cycle
`define GPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpi assertion failed");

`endif

### rtl/core/gpi_pkg.sv
// types, constants and the arctangent table of the gimbal point interpolator
// no dependencies
`default_nettype none

package gpi_pkg;

  localparam int STEPS        = 100;
  localparam int CORDIC_ITERS = 16;

  localparam int STEP_W  = $clog2(STEPS + 1);
  localparam int ITER_W  = $clog2(CORDIC_ITERS);
  localparam int COORD_W = 16;
  localparam int DIST_W  = 15;
  localparam int DEN_W   = DIST_W + STEP_W;
  localparam int NUM_W   = COORD_W + STEP_W + 1;
  localparam int CW      = NUM_W + 10;
  localparam int ANG_W   = 32;
  localparam int MAG_W   = 26;
  localparam int V_W     = 26;
  localparam int PWM_W   = 11;
  localparam int PWM_FULL_W = 21;

  localparam logic signed [ANG_W-1:0] THETA_HOME = ANG_W'(135 * 65536);
  localparam logic signed [ANG_W-1:0] PHI_MAX    = ANG_W'(180 * 65536);

  localparam logic [26:0] DIV100_M = 27'd85899346;
  localparam int          DIV100_S = 33;

  localparam logic [15:0] PHI_HALF   = 16'd90;
  localparam logic [15:0] THETA_HALF = 16'd135;
  localparam logic [19:0] PHI_M      = 20'd745655;
  localparam int          PHI_S      = 27;
  localparam logic [19:0] THETA_M    = 20'd994206;
  localparam int          THETA_S    = 28;
  localparam logic [PWM_W-1:0] PWM_BASE      = PWM_W'(250);
  localparam logic [PWM_W-1:0] THETA_PWM_MAX = PWM_W'(1300);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOADX,
    ST_ITERX,
    ST_LOADZ,
    ST_ITERZ,
    ST_DIFF,
    ST_DIV,
    ST_SUM,
    ST_PWM
  } gpi_state_e;

  typedef struct packed {
    logic              load_move;
    logic              load_x;
    logic              load_z;
    logic              iter;
    logic              diff;
    logic              div;
    logic              sum;
    logic              pwm_wr;
    logic              finish;
    logic [ITER_W-1:0] iter_idx;
    logic [STEP_W-1:0] step;
  } gpi_cmd_t;

  typedef struct packed {
    logic out_busy;
  } gpi_stat_t;

  // atan(2^-i) * 57.3 in q15.16
  function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd2949337;
      5'd1:    v = 32'd1741095;
      5'd2:    v = 32'd919947;
      5'd3:    v = 32'd466979;
      5'd4:    v = 32'd234396;
      5'd5:    v = 32'd117312;
      5'd6:    v = 32'd58670;
      5'd7:    v = 32'd29337;
      5'd8:    v = 32'd14669;
      5'd9:    v = 32'd7334;
      5'd10:   v = 32'd3667;
      5'd11:   v = 32'd1834;
      5'd12:   v = 32'd917;
      5'd13:   v = 32'd458;
      5'd14:   v = 32'd229;
      5'd15:   v = 32'd115;
      5'd16:   v = 32'd57;
      5'd17:   v = 32'd29;
      5'd18:   v = 32'd14;
      5'd19:   v = 32'd7;
      5'd20:   v = 32'd4;
      5'd21:   v = 32'd2;
      5'd22:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/gpi_ctrl.sv
// sequencing state machine of the gimbal point interpolator
// depends on gpi_pkg and gimbal_point_interpolator_top_defines.svh
`default_nettype none
`include "gimbal_point_interpolator_top_defines.svh"

module gpi_ctrl
  import gpi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_op_i,
  output logic      in_ready_o,
  input  gpi_stat_t stat_i,
  output gpi_cmd_t  cmd_o
);

  gpi_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              accept;
  logic              iter_last;

  assign accept    = in_valid_i && in_ready_o;
  assign iter_last = (iter_q == ITER_W'(CORDIC_ITERS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    iter_d     = iter_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.step     = step_q;
    cmd_o.iter_idx = iter_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (!in_op_i && step_q == '0) begin
            cmd_o.load_move = 1'b1;
            step_d          = STEP_W'(1);
          end else if (in_op_i && step_q != '0) begin
            state_d = ST_LOADX;
          end
        end
      end
      ST_LOADX: begin
        cmd_o.load_x = 1'b1;
        iter_d       = '0;
        state_d      = ST_ITERX;
      end
      ST_ITERX: begin
        cmd_o.iter = 1'b1;
        iter_d     = iter_q + 1'b1;
        if (iter_last) begin
          state_d = ST_LOADZ;
        end
      end
      ST_LOADZ: begin
        cmd_o.load_z = 1'b1;
        iter_d       = '0;
        state_d      = ST_ITERZ;
      end
      ST_ITERZ: begin
        cmd_o.iter = 1'b1;
        iter_d     = iter_q + 1'b1;
        if (iter_last) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_PWM;
      end
      ST_PWM: begin
        if (!stat_i.out_busy) begin
          cmd_o.pwm_wr = 1'b1;
          state_d      = ST_IDLE;
          if (step_q >= STEP_W'(STEPS)) begin
            cmd_o.finish = 1'b1;
            step_d       = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `GPI_ASSERT_IMP(a_step_range, 1'b1, step_q <= STEP_W'(STEPS))
  `GPI_ASSERT_NEXT(a_tick_starts, accept && in_op_i && step_q != '0, state_q == ST_LOADX)
  `GPI_ASSERT_NEXT(a_pwm_holds, state_q == ST_PWM && stat_i.out_busy, state_q == ST_PWM)
  `GPI_ASSERT_NEXT(a_finish_idle, cmd_o.finish, step_q == '0 && state_q == ST_IDLE)

endmodule

`default_nettype wire

### rtl/core/gpi_datapath.sv
// interpolation, shared cordic arctangent, smoothing and servo scaling
// depends on gpi_pkg
`default_nettype none

module gpi_datapath
  import gpi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  gpi_cmd_t                 cmd_i,
  output gpi_stat_t                stat_o,
  input  wire logic [COORD_W-1:0]  target_x_i,
  input  wire logic [COORD_W-1:0]  target_z_i,
  input  wire logic [DIST_W-1:0]   distance_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [PWM_W-1:0]         pwm_phi_o,
  output logic [PWM_W-1:0]         pwm_theta_o,
  output logic                     move_done_o
);

  logic signed [COORD_W-1:0] start_x_q, start_z_q, goal_x_q, goal_z_q;
  logic [DIST_W-1:0]         dist_q;
  logic signed [ANG_W-1:0]   theta_prev_q, phi_prev_q, th_t_q, ph_t_q;
  logic signed [CW-1:0]      cx_q, cy_q;
  logic signed [ANG_W-1:0]   cz_q;
  logic [MAG_W-1:0]          mag_t_q, mag_p_q;
  logic                      neg_t_q, neg_p_q;
  logic signed [ANG_W-1:0]   q_t_q, q_p_q;
  logic [V_W-1:0]            v_t_q, v_p_q;
  logic                      out_valid_q;
  logic [PWM_W-1:0]          pwm_phi_q, pwm_theta_q;
  logic                      done_q;

  logic signed [NUM_W-1:0]   rem_s, step_s, num_x, num_z;
  logic [DEN_W-1:0]          den;
  logic signed [CW-1:0]      dx, dy;
  logic [ANG_W-1:0]          atan_v;
  logic signed [ANG_W:0]     d_t, d_p;
  logic [ANG_W:0]            a_t, a_p;
  logic [MAG_W+26:0]         pr_t, pr_p;
  logic [MAG_W-1:0]          qm_t, qm_p;
  logic signed [ANG_W:0]     r_t, r_p;
  logic [ANG_W-1:0]          c_t, c_p;
  logic [ANG_W+9:0]          n_t, n_p;
  logic [V_W+19:0]           s_t, s_p;
  logic [PWM_FULL_W-1:0]     f_t, f_p;

  assign rem_s  = NUM_W'(signed'({1'b0, STEP_W'(STEPS)})) - NUM_W'(signed'({1'b0, cmd_i.step}));
  assign step_s = NUM_W'(signed'({1'b0, cmd_i.step}));
  assign num_x  = NUM_W'(start_x_q) * rem_s + NUM_W'(goal_x_q) * step_s;
  assign num_z  = NUM_W'(start_z_q) * rem_s + NUM_W'(goal_z_q) * step_s;
  assign den    = DEN_W'(dist_q) * DEN_W'(STEPS);

  assign dx     = cy_q >>> cmd_i.iter_idx;
  assign dy     = cx_q >>> cmd_i.iter_idx;
  assign atan_v = atan_entry(5'(cmd_i.iter_idx));

  assign d_t = (ANG_W+1)'(th_t_q) - (ANG_W+1)'(theta_prev_q);
  assign d_p = (ANG_W+1)'(cz_q) - (ANG_W+1)'(phi_prev_q);
  assign a_t = d_t[ANG_W] ? (ANG_W+1)'(-d_t) : (ANG_W+1)'(d_t);
  assign a_p = d_p[ANG_W] ? (ANG_W+1)'(-d_p) : (ANG_W+1)'(d_p);

  assign pr_t = (MAG_W+27)'(mag_t_q) * (MAG_W+27)'(DIV100_M);
  assign pr_p = (MAG_W+27)'(mag_p_q) * (MAG_W+27)'(DIV100_M);
  assign qm_t = MAG_W'(pr_t >> DIV100_S);
  assign qm_p = MAG_W'(pr_p >> DIV100_S);

  assign r_t = (ANG_W+1)'(th_t_q) + (ANG_W+1)'(q_t_q);
  assign r_p = (ANG_W+1)'(ph_t_q) + (ANG_W+1)'(q_p_q);

  always_comb begin
    if (r_t < 0) begin
      c_t = '0;
    end else begin
      c_t = ANG_W'(r_t);
    end
    if (r_p < 0) begin
      c_p = '0;
    end else if (r_p > (ANG_W+1)'(PHI_MAX)) begin
      c_p = ANG_W'(PHI_MAX);
    end else begin
      c_p = ANG_W'(r_p);
    end
  end

  assign n_t = ((ANG_W+10)'(c_t) * (ANG_W+10)'(1000)) + (ANG_W+10)'({THETA_HALF, 16'd0});
  assign n_p = ((ANG_W+10)'(c_p) * (ANG_W+10)'(1000)) + (ANG_W+10)'({PHI_HALF, 16'd0});

  assign s_t = (V_W+20)'(v_t_q) * (V_W+20)'(THETA_M);
  assign s_p = (V_W+20)'(v_p_q) * (V_W+20)'(PHI_M);
  assign f_t = PWM_FULL_W'(s_t >> THETA_S) + PWM_FULL_W'(PWM_BASE);
  assign f_p = PWM_FULL_W'(s_p >> PHI_S) + PWM_FULL_W'(PWM_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= '0;
      start_z_q    <= '0;
      goal_x_q     <= '0;
      goal_z_q     <= '0;
      dist_q       <= DIST_W'(16);
      theta_prev_q <= THETA_HOME;
      phi_prev_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load_move) begin
        goal_x_q <= target_x_i;
        goal_z_q <= target_z_i;
        dist_q   <= distance_i;
      end
      if (cmd_i.diff) begin
        theta_prev_q <= th_t_q;
        phi_prev_q   <= cz_q;
      end
      if (cmd_i.finish) begin
        start_x_q <= goal_x_q;
        start_z_q <= goal_z_q;
      end
      if (cmd_i.pwm_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      cx_q <= CW'({den, 8'd0});
      cy_q <= CW'(signed'({num_x, 8'd0}));
      cz_q <= '0;
    end else if (cmd_i.load_z) begin
      th_t_q <= THETA_HOME - cz_q;
      cx_q   <= CW'({den, 8'd0});
      cy_q   <= CW'(signed'({num_z, 8'd0}));
      cz_q   <= '0;
    end else if (cmd_i.iter) begin
      if (!cy_q[CW-1]) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + signed'(atan_v);
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - signed'(atan_v);
      end
    end
    if (cmd_i.diff) begin
      ph_t_q  <= cz_q;
      mag_t_q <= MAG_W'(a_t);
      mag_p_q <= MAG_W'(a_p);
      neg_t_q <= d_t[ANG_W];
      neg_p_q <= d_p[ANG_W];
    end
    if (cmd_i.div) begin
      q_t_q <= neg_t_q ? -ANG_W'(qm_t) : ANG_W'(qm_t);
      q_p_q <= neg_p_q ? -ANG_W'(qm_p) : ANG_W'(qm_p);
    end
    if (cmd_i.sum) begin
      v_t_q <= V_W'(n_t >> 16);
      v_p_q <= V_W'(n_p >> 16);
    end
    if (cmd_i.pwm_wr) begin
      pwm_phi_q   <= PWM_W'(f_p);
      pwm_theta_q <= (f_t > PWM_FULL_W'(THETA_PWM_MAX)) ? THETA_PWM_MAX : PWM_W'(f_t);
      done_q      <= cmd_i.finish;
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign pwm_phi_o       = pwm_phi_q;
  assign pwm_theta_o     = pwm_theta_q;
  assign move_done_o     = done_q;

endmodule

`default_nettype wire

### rtl/core/gimbal_point_interpolator_top.sv
// top level of the gimbal point interpolator: stream ports, controller, datapath
// depends on gpi_pkg, gpi_ctrl and gpi_datapath
//
// channel  dir  payload
// s_axis   in   tuser = operation, tdata = target_x, target_z, distance
// m_axis   out  tdata = pwm_phi, pwm_theta, tlast = move_done
//
// a tick word passes through load x, the x iterations, load z, the z iterations, diff, div, sum
// and pwm before its result is registered for m_axis; both arctangents use the shared cordic unit
// a move word is loaded in the idle state; words are taken one at a time from the idle state
// the result register lets the next word in while a result waits on m_axis
// a tick done while the previous result still waits holds in its last state
// reset is asynchronous, active low, and returns the stored angles to the home pose
`default_nettype none

module gimbal_point_interpolator_top
  import gpi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // target_x, target_z, distance, zero pad
  input  wire logic        s_axis_tuser_i,   // operation
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // pwm_phi, pwm_theta, zero pad
  output logic             m_axis_tlast_o
);

  gpi_cmd_t         cmd;
  gpi_stat_t        stat;
  logic [PWM_W-1:0] pwm_phi, pwm_theta;

  gpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gpi_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .target_x_i  (s_axis_tdata_i[15:0]),
    .target_z_i  (s_axis_tdata_i[31:16]),
    .distance_i  (s_axis_tdata_i[46:32]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .pwm_phi_o   (pwm_phi),
    .pwm_theta_o (pwm_theta),
    .move_done_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, pwm_theta, pwm_phi};

endmodule

`default_nettype wire
